FILE: design/ppdr_pkg.sv
// Shared types, constants and CORDIC tables for the planar pose integrator.
// Used by ppdr_cfg, ppdr_ctrl, ppdr_dp and planar_pose_dead_reckoning.
// No dependencies.
package ppdr_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_STEPS_MAX = 24;

  localparam int CFG_AW = 3;
  localparam logic REG_TIME_STEP    = 1'b0;
  localparam logic REG_HEADING_GAIN = 1'b1;

  localparam logic [15:0] TIME_STEP_RST    = 16'd3277;
  localparam logic [23:0] HEADING_GAIN_RST = 24'd133509;

  // Command group from the sequencer to the datapath
  typedef struct packed {
    logic       load;      // capture a new command beat, seed the rotator
    logic       iter;      // one rotation step
    logic [4:0] step;      // rotation step index
    logic       fix;       // undo the half-turn fold
    logic       mul;       // form partial products of speed term and trig value
    logic       sel_sin;   // 1: work on the sine / y path
    logic       del;       // combine partial products into a rounded delta
    logic       upd;       // update pose state
    logic       load_out;  // copy pose into the output register
  } ppdr_cmd_t;

  // round(atan(2^-i) * 2^32 / (2 pi))
  function automatic logic [31:0] atan_of(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'h2000_0000;
      5'd1:    a = 32'h12E4_051E;
      5'd2:    a = 32'h09FB_385B;
      5'd3:    a = 32'h0511_11D4;
      5'd4:    a = 32'h028B_0D43;
      5'd5:    a = 32'h0145_D7E1;
      5'd6:    a = 32'h00A2_F61E;
      5'd7:    a = 32'h0051_7C55;
      5'd8:    a = 32'h0028_BE53;
      5'd9:    a = 32'h0014_5F2F;
      5'd10:   a = 32'h000A_2F98;
      5'd11:   a = 32'h0005_17CC;
      5'd12:   a = 32'h0002_8BE6;
      5'd13:   a = 32'h0001_45F3;
      5'd14:   a = 32'h0000_A2FA;
      5'd15:   a = 32'h0000_517D;
      5'd16:   a = 32'h0000_28BE;
      5'd17:   a = 32'h0000_145F;
      5'd18:   a = 32'h0000_0A30;
      5'd19:   a = 32'h0000_0518;
      5'd20:   a = 32'h0000_028C;
      5'd21:   a = 32'h0000_0146;
      5'd22:   a = 32'h0000_00A3;
      5'd23:   a = 32'h0000_0051;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

  // Rotator gain K(n) * 2^30; counts below eight use the eight-step value
  function automatic logic signed [33:0] cordic_gain(input int n);
    logic signed [33:0] g;
    if (n <= 8)       g = 34'sd652039507;
    else if (n == 9)  g = 34'sd652034533;
    else if (n == 10) g = 34'sd652033290;
    else if (n == 11) g = 34'sd652032979;
    else if (n == 12) g = 34'sd652032901;
    else if (n == 13) g = 34'sd652032881;
    else if (n == 14) g = 34'sd652032877;
    else              g = 34'sd652032875;
    return g;
  endfunction

endpackage

FILE: design/ppdr_cfg.sv
// APB-style register file: integration time step and heading gain.
// Depends on ppdr_pkg.
module ppdr_cfg
  import ppdr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [15:0]       time_step,
  output logic [23:0]       heading_gain
);

  logic [15:0] time_step_r, time_step_nxt;
  logic [23:0] heading_gain_r, heading_gain_nxt;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    time_step_nxt    = time_step_r;
    heading_gain_nxt = heading_gain_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_TIME_STEP:    time_step_nxt    = pwdata[15:0];
        REG_HEADING_GAIN: heading_gain_nxt = pwdata[23:0];
        default:          time_step_nxt    = time_step_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TIME_STEP:    prdata = {16'd0, time_step_r};
      REG_HEADING_GAIN: prdata = {8'd0, heading_gain_r};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r    <= TIME_STEP_RST;
      heading_gain_r <= HEADING_GAIN_RST;
    end else begin
      time_step_r    <= time_step_nxt;
      heading_gain_r <= heading_gain_nxt;
    end
  end

  assign time_step    = time_step_r;
  assign heading_gain = heading_gain_r;

endmodule

FILE: design/ppdr_ctrl.sv
// Sequencer for the pose integrator: steps the rotator, the multiply and
// update phases, and owns the stream handshakes. Depends on ppdr_pkg.
module ppdr_ctrl
  import ppdr_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output ppdr_cmd_t cmd
);

  localparam int STEPS  = (CORDIC_STEPS > CORDIC_STEPS_MAX) ? CORDIC_STEPS_MAX :
                          ((CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS);
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CORD = 9'b000000010,
    S_FIX  = 9'b000000100,
    S_MULC = 9'b000001000,
    S_DELC = 9'b000010000,
    S_MULS = 9'b000100000,
    S_DELS = 9'b001000000,
    S_UPD  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cmd          = '0;
    cmd.step     = 5'(step_r);
    in_tready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = S_CORD;
        end
      end
      S_CORD: begin
        cmd.iter = 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_FIX;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = S_MULC;
      end
      S_MULC: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DELC;
      end
      S_DELC: begin
        cmd.del   = 1'b1;
        state_nxt = S_MULS;
      end
      S_MULS: begin
        cmd.mul     = 1'b1;
        cmd.sel_sin = 1'b1;
        state_nxt   = S_DELS;
      end
      S_DELS: begin
        cmd.del     = 1'b1;
        cmd.sel_sin = 1'b1;
        state_nxt   = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold the new pose until the output slot is free
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

FILE: design/ppdr_dp.sv
// Datapath for the pose integrator: iterative CORDIC rotator, split
// speed-times-trig multiply, saturating position update, heading wrap.
// Depends on ppdr_pkg.
module ppdr_dp
  import ppdr_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ppdr_cmd_t          cmd,
  input  logic signed [15:0] linear_speed,
  input  logic signed [15:0] turn_rate,
  input  logic [15:0]        time_step,
  input  logic [23:0]        heading_gain,
  output logic [31:0]        pos_x,
  output logic [31:0]        pos_y,
  output logic [31:0]        heading
);

  localparam int STEPS = (CORDIC_STEPS > CORDIC_STEPS_MAX) ? CORDIC_STEPS_MAX :
                         ((CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS);
  localparam logic signed [33:0] GAIN_INIT = cordic_gain(STEPS);

  // pose state
  logic signed [31:0] x_pos_r, x_pos_nxt;
  logic signed [31:0] y_pos_r, y_pos_nxt;
  logic [31:0]        head_r, head_nxt;

  // work registers
  logic signed [32:0] p_r;
  logic [31:0]        turn_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [32:0] z_r;
  logic               flip_r;
  logic signed [49:0] mul_hi_r;
  logic signed [50:0] mul_lo_r;
  logic signed [31:0] dx_r, dy_r;
  logic [31:0]        out_x_r, out_y_r, out_h_r;

  // command capture
  logic signed [32:0] p_prod;
  logic signed [40:0] turn_prod;
  logic               flip_in;
  logic [31:0]        ang_fold;

  assign p_prod    = $signed({1'b0, time_step}) * linear_speed;
  assign turn_prod = turn_rate * $signed({1'b0, heading_gain});
  assign flip_in   = head_r[31] ^ head_r[30];
  // fold into [-1/4, +1/4) turn by adding half a turn
  assign ang_fold  = {head_r[31] ^ flip_in, head_r[30:0]};

  // rotation step
  logic signed [33:0] sh_x, sh_y;
  logic signed [32:0] atan_s;
  assign sh_x   = cy_r >>> cmd.step;
  assign sh_y   = cx_r >>> cmd.step;
  assign atan_s = $signed({1'b0, atan_of(cmd.step)});

  // partial products: trig = hi * 2^17 + lo, lo unsigned
  logic signed [33:0] trig;
  logic signed [16:0] trig_hi;
  logic signed [17:0] trig_lo;
  logic signed [49:0] mul_hi;
  logic signed [50:0] mul_lo;
  assign trig    = cmd.sel_sin ? cy_r : cx_r;
  assign trig_hi = trig[33:17];
  assign trig_lo = $signed({1'b0, trig[16:0]});
  assign mul_hi  = p_r * trig_hi;
  assign mul_lo  = p_r * trig_lo;

  // rounded delta, half up
  logic signed [63:0] acc;
  logic signed [63:0] acc_sh;
  assign acc    = ($signed(64'(mul_hi_r)) <<< 17) + $signed(64'(mul_lo_r))
                + (64'sd1 <<< 37);
  assign acc_sh = acc >>> 38;

  // saturating position add
  logic signed [32:0] x_sum, y_sum;
  assign x_sum = {x_pos_r[31], x_pos_r} + {dx_r[31], dx_r};
  assign y_sum = {y_pos_r[31], y_pos_r} + {dy_r[31], dy_r};

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] == v[31]) begin
      r = v[31:0];
    end else if (v[32]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  always_comb begin
    x_pos_nxt = x_pos_r;
    y_pos_nxt = y_pos_r;
    head_nxt  = head_r;
    if (cmd.upd) begin
      x_pos_nxt = sat32(x_sum);
      y_pos_nxt = sat32(y_sum);
      head_nxt  = head_r + turn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_pos_r <= '0;
      y_pos_r <= '0;
      head_r  <= '0;
    end else begin
      x_pos_r <= x_pos_nxt;
      y_pos_r <= y_pos_nxt;
      head_r  <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r    <= p_prod;
      turn_r <= turn_prod[31:0];
      flip_r <= flip_in;
      cx_r   <= GAIN_INIT;
      cy_r   <= '0;
      z_r    <= $signed({ang_fold[31], ang_fold});
    end else if (cmd.iter) begin
      if (!z_r[32]) begin
        cx_r <= cx_r - sh_x;
        cy_r <= cy_r + sh_y;
        z_r  <= z_r - atan_s;
      end else begin
        cx_r <= cx_r + sh_x;
        cy_r <= cy_r - sh_y;
        z_r  <= z_r + atan_s;
      end
    end else if (cmd.fix && flip_r) begin
      cx_r <= -cx_r;
      cy_r <= -cy_r;
    end
    if (cmd.mul) begin
      mul_hi_r <= mul_hi;
      mul_lo_r <= mul_lo;
    end
    if (cmd.del) begin
      if (cmd.sel_sin) begin
        dy_r <= acc_sh[31:0];
      end else begin
        dx_r <= acc_sh[31:0];
      end
    end
    if (cmd.load_out) begin
      out_x_r <= x_pos_r;
      out_y_r <= y_pos_r;
      out_h_r <= head_r;
    end
  end

  assign pos_x   = out_x_r;
  assign pos_y   = out_y_r;
  assign heading = out_h_r;

endmodule

FILE: design/planar_pose_dead_reckoning.sv
// Planar pose dead reckoning top level: stream ports, APB-style registers.
// Depends on ppdr_pkg, ppdr_cfg, ppdr_ctrl and ppdr_dp.
//
// Each input beat is a velocity command (forward speed, turn rate); each
// produces one output beat with the new X/Y position and heading. Position
// moves by time_step * speed * (cos, sin) of the previous heading, with the
// trig values from an iterative CORDIC rotator that runs one step per cycle;
// the heading then advances by turn_rate * heading_gain and wraps each turn.
// A beat occupies the block from the accept cycle through the rotator steps,
// the undo of the angle fold, two multiply/round pairs and the pose update
// to the hand-off of the pose to the output register, which waits while the
// previous result still fills the output slot. in_tready returns as soon as
// the pose is in the output register, so the next command is taken while
// the previous result waits for out_tready.
module planar_pose_dead_reckoning
  import ppdr_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,     // [15:0] linear_speed, [31:16] turn_rate
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [95:0]       out_tdata,    // [31:0] pos_x, [63:32] pos_y, [95:64] heading
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  ppdr_cmd_t          cmd;
  logic [15:0]        time_step;
  logic [23:0]        heading_gain;
  logic signed [15:0] linear_speed;
  logic signed [15:0] turn_rate;
  logic [31:0]        pos_x, pos_y, heading;

  assign linear_speed = $signed(in_tdata[15:0]);
  assign turn_rate    = $signed(in_tdata[31:16]);
  assign out_tdata    = {heading, pos_y, pos_x};

  ppdr_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pready       (cfg_pready),
    .time_step    (time_step),
    .heading_gain (heading_gain)
  );

  ppdr_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  ppdr_dp #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .linear_speed (linear_speed),
    .turn_rate    (turn_rate),
    .time_step    (time_step),
    .heading_gain (heading_gain),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .heading      (heading)
  );

`ifndef SYNTHESIS
  // an accepted beat keeps the input closed while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input reopened right after accept");

  // a result appears only from the hand-off phase, never while idle
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result raised without work in progress");

  // no datapath work step while the input is open
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(cmd.iter || cmd.fix || cmd.mul || cmd.del || cmd.upd ||
                    cmd.load_out))
    else $error("datapath command while idle");
`endif

endmodule

FILE: sim/ppdr_odometry_tb_pkg.sv
`timescale 1ns / 1ps
// Pose scoreboard for the planar pose integrator testbench: predicts each new
// pose from accepted velocity commands and checks output beats in order.
// Depends on ppdr_pkg for the step count and its limit.
package ppdr_odometry_tb_pkg;
  import ppdr_pkg::*;

  typedef struct {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] heading;
  } pose_t;

  localparam longint ROUND_HALF = longint'(1) << 37;
  localparam longint POS_MAX    = 64'sd2147483647;
  localparam longint POS_MIN    = -64'sd2147483648;

  class odometry_board;
    longint      x_pos;
    longint      y_pos;
    logic [31:0] heading;
    logic [15:0] step_q016;
    logic [23:0] turn_gain;
    pose_t       expected_poses[$];
    int          mismatches;

    function new();
      x_pos      = 0;
      y_pos      = 0;
      heading    = '0;
      step_q016  = 16'd3277;
      turn_gain  = 24'd133509;
      mismatches = 0;
    endfunction

    // Angle of atan(2^-i) in binary-angle units
    function longint atan_turn(input int i);
      case (i)
        0:       return 64'h2000_0000;
        1:       return 64'h12E4_051E;
        2:       return 64'h09FB_385B;
        3:       return 64'h0511_11D4;
        4:       return 64'h028B_0D43;
        5:       return 64'h0145_D7E1;
        6:       return 64'h00A2_F61E;
        7:       return 64'h0051_7C55;
        8:       return 64'h0028_BE53;
        9:       return 64'h0014_5F2F;
        10:      return 64'h000A_2F98;
        11:      return 64'h0005_17CC;
        12:      return 64'h0002_8BE6;
        13:      return 64'h0001_45F3;
        14:      return 64'h0000_A2FA;
        15:      return 64'h0000_517D;
        16:      return 64'h0000_28BE;
        17:      return 64'h0000_145F;
        18:      return 64'h0000_0A30;
        19:      return 64'h0000_0518;
        20:      return 64'h0000_028C;
        21:      return 64'h0000_0146;
        22:      return 64'h0000_00A3;
        default: return 64'h0000_0051;
      endcase
    endfunction

    // Rotator start value K(n) * 2^30; short rotators reuse the eight-step value
    function longint rotator_gain(input int n);
      case (n)
        9:       return 652034533;
        10:      return 652033290;
        11:      return 652032979;
        12:      return 652032901;
        13:      return 652032881;
        14:      return 652032877;
        default: return (n <= 8) ? 652039507 : 652032875;
      endcase
    endfunction

    function void rotate(input logic [31:0] angle, output longint c, output longint s);
      int          n;
      int          i;
      logic        flip;
      logic [31:0] folded;
      longint      x, y, z, dx, dy;
      n = CORDIC_STEPS_DEF;
      if (n > CORDIC_STEPS_MAX) n = CORDIC_STEPS_MAX;
      if (n < 1) n = 1;
      // fold the left half-plane over by half a turn, negate at the end
      flip   = angle[31] ^ angle[30];
      folded = flip ? angle + 32'h8000_0000 : angle;
      z = longint'($signed(folded));
      x = rotator_gain(n);
      y = 0;
      for (i = 0; i < n; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - atan_turn(i);
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + atan_turn(i);
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function longint clip32(input longint v);
      if (v > POS_MAX) return POS_MAX;
      if (v < POS_MIN) return POS_MIN;
      return v;
    endfunction

    function void note_command(input logic signed [15:0] speed,
                               input logic signed [15:0] turn);
      longint c, s, p, turn_step;
      pose_t  pose;
      rotate(heading, c, s);
      p = longint'(step_q016) * longint'(speed);
      x_pos = clip32(x_pos + ((p * c + ROUND_HALF) >>> 38));
      y_pos = clip32(y_pos + ((p * s + ROUND_HALF) >>> 38));
      turn_step = longint'(turn) * longint'(turn_gain);
      heading = heading + turn_step[31:0];
      pose.pos_x   = x_pos[31:0];
      pose.pos_y   = y_pos[31:0];
      pose.heading = heading;
      expected_poses.push_back(pose);
    endfunction

    task flag_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_pose(input logic [95:0] beat);
      pose_t want;
      if (expected_poses.size() == 0) begin
        flag_mismatch($sformatf("pose beat %h with nothing pending", beat));
        return;
      end
      want = expected_poses.pop_front();
      if (beat[31:0] !== want.pos_x)
        flag_mismatch($sformatf("pos_x got %0d want %0d",
                                $signed(beat[31:0]), $signed(want.pos_x)));
      if (beat[63:32] !== want.pos_y)
        flag_mismatch($sformatf("pos_y got %0d want %0d",
                                $signed(beat[63:32]), $signed(want.pos_y)));
      if (beat[95:64] !== want.heading)
        flag_mismatch($sformatf("heading got %h want %h", beat[95:64], want.heading));
    endtask

    function int pending();
      return expected_poses.size();
    endfunction
  endclass

endpackage

FILE: sim/tb_planar_pose_dead_reckoning.sv
`timescale 1ns / 1ps
// Testbench top for planar_pose_dead_reckoning: stream and register drivers,
// directed and random velocity commands, pose checks against the scoreboard.
// Depends on ppdr_pkg and ppdr_odometry_tb_pkg.
module tb_planar_pose_dead_reckoning;
  import ppdr_pkg::*;
  import ppdr_odometry_tb_pkg::*;

  localparam int ITEM_CYCLES   = CORDIC_STEPS_DEF + 8;
  localparam int SETTLE_CYCLES = 2 * ITEM_CYCLES;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int HOLDOFF_LONG  = 400;

  localparam logic [CFG_AW-1:0] ADDR_TIME_STEP    = CFG_AW'(4 * REG_TIME_STEP);
  localparam logic [CFG_AW-1:0] ADDR_HEADING_GAIN = CFG_AW'(4 * REG_HEADING_GAIN);

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [31:0]       in_tdata;     // [15:0] linear_speed, [31:16] turn_rate
  logic              out_tvalid;
  logic              out_tready;
  logic [95:0]       out_tdata;    // [31:0] pos_x, [63:32] pos_y, [95:64] heading
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  odometry_board board = new();
  bit            idle_on;
  int            holdoff_req;

  planar_pose_dead_reckoning dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // Output side: random stalls, plus a long hold-off when asked for
  initial begin : pose_sink
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_req > 0) begin
        stall_left  = holdoff_req;
        holdoff_req = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                 : $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) board.check_pose(out_tdata);
    end
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // Lean on the extremes now and then, otherwise any 16-bit value
  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 15))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic apb_access(input logic is_write, input logic [CFG_AW-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= is_write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic check_register(input logic [CFG_AW-1:0] addr, input logic [31:0] want);
    logic [31:0] got;
    apb_access(1'b0, addr, 32'd0, got);
    if (got !== want)
      board.flag_mismatch($sformatf("register @%0d reads %h want %h", addr, got, want));
  endtask

  task automatic set_config(input logic [15:0] step, input logic [23:0] gain);
    logic [31:0] unused;
    apb_access(1'b1, ADDR_TIME_STEP, {16'd0, step}, unused);
    apb_access(1'b1, ADDR_HEADING_GAIN, {8'd0, gain}, unused);
    board.step_q016 = step;
    board.turn_gain = gain;
    check_register(ADDR_TIME_STEP, {16'd0, step});
    check_register(ADDR_HEADING_GAIN, {8'd0, gain});
  endtask

  task automatic send_command(input logic signed [15:0] speed,
                              input logic signed [15:0] turn);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {turn, speed};
    do @(posedge clk); while (!in_tready);
    board.note_command(speed, turn);
  endtask

  // Hold the input until every pose is out, then let the block settle
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] aim;
    int          ph;
    int          sat_hold;
    int          n;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    idle_on     = 1'b0;
    holdoff_req = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    check_register(ADDR_TIME_STEP, {16'd0, TIME_STEP_RST});
    check_register(ADDR_HEADING_GAIN, {8'd0, HEADING_GAIN_RST});

    // Field extremes at the reset settings, including heading wrap
    send_command(16'sd0, 16'sd0);
    send_command(16'sd32767, 16'sd0);
    send_command(-16'sd32768, 16'sd0);
    send_command(16'sd256, 16'sd32767);
    send_command(-16'sd256, -16'sd32768);
    send_command(16'sd1, -16'sd1);
    send_command(-16'sd1, 16'sd1);

    // Quarter turns per beat: visit every quadrant of the fold
    wait_drained();
    set_config(16'hFFFF, 24'h40_0000);
    idle_on = 1'b1;
    repeat (4) send_command(16'sd32767, 16'sd256);
    send_command(-16'sd32768, 16'sd128);
    send_command(16'sd32767, -16'sd32768);
    send_command(-16'sd32768, -16'sd1);

    wait_drained();
    set_config(16'h0000, 24'hFF_FFFF);
    send_command(16'sd32767, 16'sd32767);
    send_command(-16'sd32768, -16'sd32768);
    send_command(16'sd12345, -16'sd12345);

    wait_drained();
    set_config(16'h0001, 24'h00_0000);
    send_command(16'sd32767, 16'sd1234);
    send_command(-16'sd32768, 16'sd0);

    for (ph = 0; ph < 5; ph++) begin
      wait_drained();
      case (ph)
        0:       set_config(TIME_STEP_RST, HEADING_GAIN_RST);
        2:       set_config(16'hFFFF, 24'hFF_FFFF);
        4:       set_config(16'($urandom_range(1, 255)), 24'($urandom));
        default: set_config(16'($urandom), 24'($urandom));
      endcase
      idle_on = (ph != 3);
      // output stalls long enough for the block to back up onto the input
      if (ph == 2) holdoff_req = HOLDOFF_LONG;
      repeat (32) send_command(pick_field(), pick_field());
    end

    // Point the heading just below zero, then freeze it and drive X into its limit
    wait_drained();
    set_config(16'hFFFF, 24'h01_0000);
    aim = 32'h0 - board.heading;
    send_command(16'sd0, aim[31:16]);
    wait_drained();
    set_config(16'hFFFF, 24'h00_0000);
    idle_on  = 1'b1;
    sat_hold = 0;
    n        = 0;
    while (sat_hold < 12 && n < 400) begin
      send_command(16'($urandom_range(30000, 32767)), pick_field());
      n++;
      if (board.x_pos == POS_MAX) sat_hold++;
    end

    wait_drained();
    if (board.pending() != 0)
      board.flag_mismatch($sformatf("%0d poses never arrived", board.pending()));
    if (board.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
